FILE: hw/rtl/dwma_pkg.sv
// shared types and constants of the deadband weighted moving average
package dwma_pkg;

  // sample and result widths
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned SMP_W    = 8;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned WLEN_W   = 5;
  localparam int unsigned WGT_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  // sum of at most 31 entries plus 15 extra copies of the newest, 8 bit each
  localparam int unsigned SUM_W    = 14;
  // divisor is window length plus weight, at most 46
  localparam int unsigned DIV_W    = 6;
  // counts the divider steps, one per dividend bit
  localparam int unsigned DCNT_W   = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT    = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd0;
  localparam logic [WLEN_W-1:0] WINDOW_RST    = 5'd16;
  localparam logic [WGT_W-1:0]  WEIGHT_RST    = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MODP,
    ST_SUM,
    ST_DRAIN,
    ST_DIVL,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

FILE: hw/rtl/dwma_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module dwma_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dwma_pkg::SUM_W-1:0]    dividend_i,
  input  logic [dwma_pkg::DIV_W-1:0]    divisor_i,
  output logic [dwma_pkg::SUM_W-1:0]    quot_o,
  output logic                          done_o
);
  import dwma_pkg::*;

  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;
  logic              qbit;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, divisor_i};
    qbit    = (rem_sh >= {1'b0, divisor_i});
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // dividend shifts out at the top while quotient bits fill in below
      dvd_d = {dvd_q[SUM_W-2:0], qbit};
      rem_d = qbit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign quot_o = dvd_q;
  assign done_o = done_q;

endmodule

FILE: hw/rtl/deadband_weighted_moving_average_top.sv
// top level of the deadband weighted moving average
// Each input word is a signed 16-bit rate sample; it is scaled down by 256
// (toward zero), forced to zero when its magnitude is below the threshold,
// and stored at the next ring position. The result word carries the magnitude
// of the weighted window average and the stored sample. One sample is in
// flight at a time: once it is accepted, the advanced position is brought
// back inside the window by length steps (one whenever the position wraps
// to zero, more when the window was shortened below the current position),
// then the ring is swept through its single read port, one entry a cycle,
// and the sum is divided by the 14-step bit-serial divider.
// A finished result waits in the output register while the next sample is
// accepted. The ring reads as zero after reset through per-entry valid bits,
// so no clearing pass is needed.
module deadband_weighted_moving_average_top #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dwma_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dwma_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  // sample stream in
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [15:0]                        s_axis_tdata,  // raw_rate
  // result stream out
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [15:0]                        m_axis_tdata   // smoothed_level, gated_sample
);
  import dwma_pkg::*;

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned IW = (PW > WLEN_W) ? PW : WLEN_W;

  // configuration registers
  logic [THR_W-1:0]  thr_q;
  logic [WLEN_W-1:0] wlen_q;
  logic [WGT_W-1:0]  wgt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THRESHOLD_RST;
      wlen_q <= WINDOW_RST;
      wgt_q  <= WEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thr_q  <= cfg_data_i;
        CFG_WINDOW:    wlen_q <= cfg_data_i[WLEN_W-1:0];
        CFG_WEIGHT:    wgt_q  <= cfg_data_i[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective window length, clamped to 1..RING_DEPTH
  logic [WLEN_W-1:0] len_eff;
  always_comb begin
    if (wlen_q == '0) begin
      len_eff = WLEN_W'(1);
    end else if ({4'b0, wlen_q} > 9'(RING_DEPTH)) begin
      len_eff = WLEN_W'(RING_DEPTH);
    end else begin
      len_eff = wlen_q;
    end
  end

  logic [DIV_W-1:0] divisor;
  assign divisor = DIV_W'(len_eff) + DIV_W'(wgt_q);

  // scale and deadband of the incoming word
  logic [RAW_W-1:0]        raw;
  logic signed [SMP_W-1:0] scaled;
  logic [SMP_W-1:0]        scaled_mag;
  logic signed [SMP_W-1:0] gated;

  always_comb begin
    raw        = s_axis_tdata;
    // arithmetic shift rounds down, so bump negatives with a fraction
    scaled     = $signed(raw[RAW_W-1:RAW_W-SMP_W])
               + $signed({{(SMP_W-1){1'b0}}, raw[RAW_W-1] & (raw[RAW_W-SMP_W-1:0] != '0)});
    scaled_mag = scaled[SMP_W-1] ? SMP_W'(-scaled) : scaled;
    gated      = (scaled_mag < thr_q) ? '0 : scaled;
  end

  logic signed [12:0] prod;
  assign prod = gated * $signed({1'b0, wgt_q});

  // state
  state_e                  state_q, state_d;
  logic [PW-1:0]           pos_q, pos_d;
  logic [5:0]              p_q, p_d;
  logic [PW-1:0]           idx_q, idx_d;
  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic signed [SMP_W-1:0] gated_q, gated_d;
  logic                    rd_vld_q, rd_vld_d;
  logic                    wr_en;
  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quot;
  logic [SUM_W-1:0]        acc_mag;
  logic                    out_load;

  // ring storage with per-entry valid bits
  logic [SMP_W-1:0] ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_q;
  logic [SMP_W-1:0] rd_data_q;
  logic             rd_ok_q;
  logic [PW-1:0]    wr_addr;
  logic signed [SMP_W-1:0] rd_sample;

  assign wr_addr   = PW'(p_q);
  assign rd_sample = rd_ok_q ? $signed(rd_data_q) : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= gated_q;
    end
    rd_data_q <= ring_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      rd_ok_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        ring_vld_q[wr_addr] <= 1'b1;
      end
      rd_ok_q <= ring_vld_q[idx_q];
    end
  end

  assign acc_mag = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);

  // output register
  logic             m_vld_q;
  logic [LEVEL_W-1:0] m_level_q;
  logic [SMP_W-1:0]   m_gated_q;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    p_d       = p_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    gated_d   = gated_q;
    rd_vld_d  = 1'b0;
    wr_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          gated_d = gated;
          p_d     = 6'(pos_q) + 6'd1;
          acc_d   = SUM_W'(prod);
          state_d = ST_MODP;
        end
      end
      ST_MODP: begin
        // one length step per cycle until the position is inside the window
        if (p_q >= {1'b0, len_eff}) begin
          p_d = p_q - {1'b0, len_eff};
        end else begin
          pos_d   = PW'(p_q);
          wr_en   = 1'b1;
          idx_d   = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        rd_vld_d = 1'b1;
        if (rd_vld_q) begin
          acc_d = acc_q + SUM_W'(rd_sample);
        end
        idx_d = idx_q + 1'b1;
        if (IW'(idx_q) == IW'(len_eff - WLEN_W'(1))) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        acc_d   = acc_q + SUM_W'(rd_sample);
        state_d = ST_DIVL;
      end
      ST_DIVL: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_q    <= '0;
      rd_vld_q <= 1'b0;
      m_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      rd_vld_q <= rd_vld_d;
      if (out_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    idx_q   <= idx_d;
    acc_q   <= acc_d;
    gated_q <= gated_d;
    if (out_load) begin
      m_level_q <= div_quot[LEVEL_W-1:0];
      m_gated_q <= gated_q;
    end
  end

  dwma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_mag),
    .divisor_i  (divisor),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {m_gated_q, m_level_q};

endmodule

FILE: bench/tb_deadband_weighted_moving_average_top.sv
// self-checking bench for the deadband weighted moving average, predicted word by word
module tb_deadband_weighted_moving_average_top;
  import dwma_pkg::*;

  localparam int RING_N = 16;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  typedef struct packed {
    logic [LEVEL_W-1:0]       level;
    logic signed [SMP_W-1:0]  gated;
  } avg_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]  cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // raw_rate
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;        // smoothed_level, gated_sample

  deadband_weighted_moving_average_top #(.RING_DEPTH(RING_N)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // shadow of the block's registers and ring
  logic [THR_W-1:0]        shadow_thr = THRESHOLD_RST;
  logic [WLEN_W-1:0]       shadow_wlen = WINDOW_RST;
  logic [WGT_W-1:0]        shadow_wgt = WEIGHT_RST;
  logic signed [SMP_W-1:0] shadow_ring [RING_N];
  int                      shadow_pos = 0;

  logic [15:0]   raw_q[$];
  avg_result_t   level_q[$];
  int            mismatches = 0;
  int            cfg_writes = 0;
  int            src_idle_pct = 0;
  int            snk_stall_pct = 0;
  logic          in_taken = 1'b0;

  initial begin
    for (int i = 0; i < RING_N; i++) shadow_ring[i] = '0;
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic avg_result_t predict_average(input logic [15:0] raw);
    avg_result_t r;
    int sample, scaled, mag, len, sum, avg;
    sample = $signed(raw);
    scaled = sample / 256;
    mag = (scaled < 0) ? -scaled : scaled;
    if (mag < int'(shadow_thr)) scaled = 0;
    len = int'(shadow_wlen);
    if (len < 1) len = 1;
    if (len > RING_N) len = RING_N;
    shadow_pos = (shadow_pos + 1) % len;
    shadow_ring[shadow_pos] = scaled[SMP_W-1:0];
    sum = 0;
    for (int i = 0; i < len; i++) sum += shadow_ring[i];
    sum += shadow_ring[shadow_pos] * int'(shadow_wgt);
    avg = sum / (len + int'(shadow_wgt));
    if (avg < 0) avg = -avg;
    r.level = avg[LEVEL_W-1:0];
    r.gated = scaled[SMP_W-1:0];
    return r;
  endfunction

  function automatic void note_mismatch(input avg_result_t want, input avg_result_t got,
                                        input bit had_want);
    if (mismatches < 10) begin
      if (had_want)
        $display("mismatch: level exp %0d got %0d, gated exp %0d got %0d",
                 want.level, got.level, want.gated, got.gated);
      else
        $display("unexpected result word: level %0d gated %0d", got.level, got.gated);
    end
    mismatches++;
  endfunction

  // driver: sample stream and result back-pressure
  always @(negedge clk_i) begin : drive
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (raw_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tdata  <= raw_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // monitor: checks result words, tracks register writes, predicts accepted samples
  always @(posedge clk_i) begin : watch
    avg_result_t got, want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.level = m_axis_tdata[7:0];
        got.gated = m_axis_tdata[15:8];
        if (level_q.size() == 0) begin
          want = '0;
          note_mismatch(want, got, 1'b0);
        end else begin
          want = level_q.pop_front();
          if (got.level !== want.level || got.gated !== want.gated)
            note_mismatch(want, got, 1'b1);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_THRESHOLD: shadow_thr <= cfg_data_i[THR_W-1:0];
          CFG_WINDOW:    shadow_wlen <= cfg_data_i[WLEN_W-1:0];
          CFG_WEIGHT:    shadow_wgt <= cfg_data_i[WGT_W-1:0];
          default: ;
        endcase
        cfg_writes <= cfg_writes + 1;
      end
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) level_q.push_back(predict_average(s_axis_tdata));
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    int seen;
    seen = cfg_writes;
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    while (cfg_writes == seen) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // every queued sample sent and answered, then room for the block to go quiet
  task automatic wait_idle();
    while (raw_q.size() != 0 || s_axis_tvalid || level_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  function automatic void set_idling(input int mode);
    case (mode % 4)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
      default: begin src_idle_pct = 23; snk_stall_pct = 23; end
    endcase
  endfunction

  function automatic logic [15:0] pick_raw();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom_range(0, 65535) - 32768;
      4, 5, 6: v = $urandom_range(0, 20480) - 10240;
      7: begin
        case ($urandom_range(5))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = -1;
          4: v = 255;
          default: v = -255;
        endcase
      end
      default: begin
        // around the deadband edge
        v = int'(shadow_thr) * 256 - 256 + $urandom_range(0, 511);
        if (v > 32767) v = 32767;
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v[15:0];
  endfunction

  initial begin : main
    logic [15:0] dir_a [10];
    int n;
    dir_a = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h00FF,
              16'h0100, 16'hFF00, 16'hFEFF, 16'h5555, 16'hAAAA};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, extremes and rounding toward zero
    set_idling(0);
    foreach (dir_a[i]) raw_q.push_back(dir_a[i]);
    wait_idle();

    // threshold at the largest magnitude, single entry window, no extra weight
    write_reg(CFG_THRESHOLD, 8'd128);
    write_reg(CFG_WINDOW, 8'd1);
    write_reg(CFG_WEIGHT, 8'd0);
    raw_q.push_back(16'h7FFF);
    raw_q.push_back(16'h8000);
    raw_q.push_back(16'h8100);
    wait_idle();

    // threshold above every magnitude, zero length, top weight
    write_reg(CFG_THRESHOLD, 8'd200);
    write_reg(CFG_WINDOW, 8'h00);
    write_reg(CFG_WEIGHT, 8'd15);
    raw_q.push_back(16'h7FFF);
    raw_q.push_back(16'h8000);
    wait_idle();

    // length past the ring saturates, unused data bits dropped
    set_idling(3);
    write_reg(CFG_THRESHOLD, 8'd3);
    write_reg(CFG_WINDOW, 8'hFF);
    write_reg(CFG_WEIGHT, 8'hAF);
    raw_q.push_back(16'h0200);
    raw_q.push_back(16'h0300);
    raw_q.push_back(16'hFD00);
    repeat (3) raw_q.push_back(16'h7FFF);
    wait_idle();

    // shorten the window below the current position
    write_reg(CFG_WINDOW, 8'hE3);
    write_reg(CFG_NONE, 8'h5A);
    raw_q.push_back(16'h8000);
    raw_q.push_back(16'h1234);
    raw_q.push_back(16'h7FFF);
    wait_idle();

    for (int phase = 0; phase < 12; phase++) begin
      set_idling(phase);
      case ($urandom_range(5))
        0: write_reg(CFG_THRESHOLD, 8'd128);
        1: write_reg(CFG_THRESHOLD, 8'($urandom_range(129, 255)));
        default: write_reg(CFG_THRESHOLD, 8'($urandom_range(0, 40)));
      endcase
      if ($urandom_range(4) == 0) write_reg(CFG_WINDOW, 8'($urandom_range(0, 255)));
      else write_reg(CFG_WINDOW, 8'($urandom_range(1, 16)));
      write_reg(CFG_WEIGHT, 8'($urandom_range(0, 255)));
      n = $urandom_range(40, 60);
      for (int k = 0; k < n; k++) raw_q.push_back(pick_raw());
      wait_idle();
    end

    if (mismatches == 0 && level_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (level_q.size() != 0) $display("%0d result words never arrived", level_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
